### src/wts_pkg.sv
// Shared types, constants and helper functions of the weekly time switch.
package wts_pkg;

    // Table shape
    localparam int SLOTS_PER_DAY = 2;
    localparam int DAYS          = 7;
    localparam int DAY_W         = 3;
    localparam int MIN_W         = 11;
    localparam int MIN_PER_HOUR  = 60;
    localparam int TIMES_W       = 2 * MIN_W;

    // Input item kinds carried on tuser
    typedef enum logic [1:0] {
        KIND_EVAL  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_free;
    } t_status;

    // Hour and minute to minutes of the day, formed without range checks.
    function automatic logic [MIN_W-1:0] to_minutes(input logic [4:0] h, input logic [5:0] m);
        logic [MIN_W-1:0] prod;
        prod = MIN_W'(h) * MIN_W'(MIN_PER_HOUR);
        return prod + MIN_W'(m);
    endfunction

    // Clock weekday to day index: (weekday + 5) mod 7.
    function automatic logic [DAY_W-1:0] weekday_to_day(input logic [DAY_W-1:0] w);
        logic [DAY_W-1:0] d;
        case (w)
            3'd0:    d = 3'd5;
            3'd1:    d = 3'd6;
            3'd2:    d = 3'd0;
            3'd3:    d = 3'd1;
            3'd4:    d = 3'd2;
            3'd5:    d = 3'd3;
            3'd6:    d = 3'd4;
            default: d = 3'd5;
        endcase
        return d;
    endfunction

    // Previous day index: (day + 6) mod 7.
    function automatic logic [DAY_W-1:0] prev_day(input logic [DAY_W-1:0] d);
        return (d == '0) ? DAY_W'(DAYS - 1) : d - 1'b1;
    endfunction

    // Interval test with midnight wrap; an empty interval never matches.
    function automatic logic in_interval(input logic [MIN_W-1:0] t,
                                         input logic [MIN_W-1:0] a,
                                         input logic [MIN_W-1:0] b);
        logic res;
        if (a < b) begin
            res = (t >= a) && (t < b);
        end else if (a > b) begin
            res = (t >= a) || (t < b);
        end else begin
            res = 1'b0;
        end
        return res;
    endfunction

endpackage

### src/wts_ctrl.sv
// Controller state machine of the weekly time switch.
module wts_ctrl
    import wts_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_LOOKUP
    } t_state;

    t_state r_state, n_state;

    // Next state and commands
    always_comb begin
        n_state        = r_state;
        o_cmd.capture  = 1'b0;
        o_cmd.load_out = 1'b0;
        o_in_ready     = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### src/wts_datapath.sv
// Datapath of the weekly time switch: slot memories, enable bits, compare and output.
module wts_datapath
    import wts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    input  logic [1:0]  i_kind,
    input  logic [2:0]  i_weekday,
    input  logic [4:0]  i_hour,
    input  logic [5:0]  i_minute,
    input  logic        i_enable,
    input  logic [2:0]  i_day,
    input  logic [1:0]  i_slot_number,
    input  logic [4:0]  i_on_hour,
    input  logic [5:0]  i_on_minute,
    input  logic [4:0]  i_off_hour,
    input  logic [5:0]  i_off_minute,
    input  logic        i_slot_enable,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_lamp_on,
    output logic        o_accepted
);

    logic [DAY_W-1:0]   w_today;
    logic [DAY_W-1:0]   w_yday;
    logic               w_kind_write;
    logic               w_write_ok;
    logic [TIMES_W-1:0] w_wr_times;
    logic               w_hit;

    logic [TIMES_W-1:0]       r_mem [DAYS][SLOTS_PER_DAY];
    logic [SLOTS_PER_DAY-1:0] r_en [DAYS];
    logic [TIMES_W-1:0]       r_rd_today [SLOTS_PER_DAY];
    logic [TIMES_W-1:0]       r_rd_yday  [SLOTS_PER_DAY];
    logic [SLOTS_PER_DAY-1:0] r_en_today;
    logic [SLOTS_PER_DAY-1:0] r_en_yday;
    logic [1:0]               r_kind;
    logic                     r_enable;
    logic [MIN_W-1:0]         r_time;
    logic                     r_ok;
    logic                     r_lamp;
    logic                     r_out_valid;
    logic                     r_out_lamp;
    logic                     r_out_acc;

    // Decode of the item at capture
    assign w_today      = weekday_to_day(i_weekday);
    assign w_yday       = prev_day(w_today);
    assign w_kind_write = (t_kind'(i_kind) == KIND_WRITE);
    assign w_write_ok   = ({1'b0, i_day} < 4'(DAYS))
                       && ({1'b0, i_slot_number} < 3'(SLOTS_PER_DAY));
    assign w_wr_times   = {to_minutes(i_on_hour, i_on_minute),
                           to_minutes(i_off_hour, i_off_minute)};

    // One memory of slot times per slot lane, indexed by day
    always_ff @(posedge i_clk) begin
        for (int s = 0; s < SLOTS_PER_DAY; s++) begin
            if (i_cmd.capture && w_kind_write && w_write_ok
                && (i_slot_number == 2'(s))) begin
                r_mem[i_day][s] <= w_wr_times;
            end
            if (i_cmd.capture) begin
                r_rd_today[s] <= r_mem[w_today][s];
                r_rd_yday[s]  <= r_mem[w_yday][s];
            end
        end
    end

    // Slot enable bits: cleared at reset and by a clear transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < DAYS; d++) begin
                r_en[d] <= '0;
            end
        end else if (i_cmd.capture) begin
            if (t_kind'(i_kind) == KIND_CLEAR) begin
                for (int d = 0; d < DAYS; d++) begin
                    r_en[d] <= '0;
                end
            end else if (w_kind_write && w_write_ok) begin
                for (int s = 0; s < SLOTS_PER_DAY; s++) begin
                    if (i_slot_number == 2'(s)) begin
                        r_en[i_day][s] <= i_slot_enable;
                    end
                end
            end
        end
    end

    // Item registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind     <= i_kind;
            r_enable   <= i_enable;
            r_time     <= to_minutes(i_hour, i_minute);
            r_en_today <= r_en[w_today];
            r_en_yday  <= r_en[w_yday];
            case (t_kind'(i_kind))
                KIND_EVAL:  r_ok <= 1'b1;
                KIND_WRITE: r_ok <= w_write_ok;
                KIND_CLEAR: r_ok <= 1'b1;
                default:    r_ok <= 1'b0;
            endcase
        end
    end

    // Slot compare across lanes of today and the overnight tail of yesterday
    always_comb begin
        logic [MIN_W-1:0] on_t, off_t, on_y, off_y;
        w_hit = 1'b0;
        for (int s = 0; s < SLOTS_PER_DAY; s++) begin
            on_t  = r_rd_today[s][TIMES_W-1:MIN_W];
            off_t = r_rd_today[s][MIN_W-1:0];
            on_y  = r_rd_yday[s][TIMES_W-1:MIN_W];
            off_y = r_rd_yday[s][MIN_W-1:0];
            if (r_en_today[s] && in_interval(r_time, on_t, off_t)) begin
                w_hit = 1'b1;
            end
            if (r_en_yday[s] && (on_y > off_y) && (r_time < off_y)) begin
                w_hit = 1'b1;
            end
        end
    end

    // Lamp state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lamp      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
                if (t_kind'(r_kind) == KIND_EVAL) begin
                    r_lamp <= r_enable & w_hit;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_lamp <= (t_kind'(r_kind) == KIND_EVAL) ? (r_enable & w_hit) : r_lamp;
            r_out_acc  <= r_ok;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_lamp_on         = r_out_lamp;
    assign o_accepted        = r_out_acc;

endmodule

### src/weekly_time_switch_unit.sv
// Top level of the weekly time switch.
//
// Usage: items arrive on the slave stream (s_axis_*). tuser carries the kind:
// evaluate, write one slot, or clear all slots. tdata carries the remaining
// fields. Every item yields exactly one result on the master stream
// (m_axis_*): the lamp state (new after an evaluation, held otherwise) and
// an accepted flag (low for a refused write or an unused kind).
// The capture state takes the item, writes the slot memory and reads today's
// and yesterday's rows; the lookup state then compares all slots of both rows
// and loads the output register once that register is free. A new item is
// taken only in the capture state, after the last one has left the lookup
// state; the result goes from the item registers into the output register.
// The output register lets the next item be taken while a result waits; if
// the receiver stalls, the block holds that second item in its compare step
// and takes no further input until the output register frees.
// Reset (i_rst_n low, synchronous) disables every slot, turns the lamp off
// and empties the output register; no clearing pass is needed.
module weekly_time_switch_unit
    import wts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: weekday[2:0], hour[7:3], minute[13:8], enable[14], day[17:15],
    // slot_number[19:18], on_hour[24:20], on_minute[30:25], off_hour[35:31],
    // off_minute[41:36], slot_enable[42], zero fill [47:43]
    input  logic [47:0] s_axis_tdata,
    // tuser: kind[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: lamp_on[0], accepted[1], zero fill [7:2]
    output logic [7:0]  m_axis_tdata
);

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_lamp_on;
    logic    w_accepted;

    wts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    wts_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_kind        (s_axis_tuser),
        .i_weekday     (s_axis_tdata[2:0]),
        .i_hour        (s_axis_tdata[7:3]),
        .i_minute      (s_axis_tdata[13:8]),
        .i_enable      (s_axis_tdata[14]),
        .i_day         (s_axis_tdata[17:15]),
        .i_slot_number (s_axis_tdata[19:18]),
        .i_on_hour     (s_axis_tdata[24:20]),
        .i_on_minute   (s_axis_tdata[30:25]),
        .i_off_hour    (s_axis_tdata[35:31]),
        .i_off_minute  (s_axis_tdata[41:36]),
        .i_slot_enable (s_axis_tdata[42]),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_lamp_on     (w_lamp_on),
        .o_accepted    (w_accepted)
    );

    // Result packing
    assign m_axis_tdata = {6'b0, w_accepted, w_lamp_on};

endmodule

### bench/wts_lamp_checker.sv
// Checker for the weekly time switch: it predicts the lamp results and compares them.
`timescale 1ns / 1ps

module wts_lamp_checker
    import wts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    // Input tdata: weekday[2:0], hour[7:3], minute[13:8], enable[14], day[17:15],
    // slot_number[19:18], on_hour[24:20], on_minute[30:25], off_hour[35:31],
    // off_minute[41:36], slot_enable[42], zero fill [47:43]
    input  logic [47:0] i_in_data,
    // Input tuser: kind[1:0]
    input  logic [1:0]  i_in_kind,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    // Output tdata: lamp_on[0], accepted[1], zero fill [7:2]
    input  logic [7:0]  i_out_data,
    output int          o_mismatches,
    output int          o_pending
);

    localparam int ENTRIES = DAYS * SLOTS_PER_DAY;

    typedef struct packed {
        logic lamp_on;
        logic accepted;
    } t_lamp_result;

    // Own copy of the slot table and the lamp.
    logic [MIN_W-1:0] on_tbl  [ENTRIES];
    logic [MIN_W-1:0] off_tbl [ENTRIES];
    logic             en_tbl  [ENTRIES];
    logic             lamp_state;

    t_lamp_result expected_lamp_q[$];
    int           mismatch_count = 0;

    // Minutes of the day, no range check, kept at the table width.
    function automatic logic [MIN_W-1:0] minutes_of(input logic [4:0] h, input logic [5:0] m);
        logic [MIN_W-1:0] total;
        total = MIN_W'(h) * MIN_W'(MIN_PER_HOUR) + MIN_W'(m);
        return total;
    endfunction

    // True when time t falls in [a, b), wrapping past midnight when a is above b.
    function automatic logic slot_covers(input logic [MIN_W-1:0] t, input logic [MIN_W-1:0] a,
                                         input logic [MIN_W-1:0] b);
        logic hit;
        if (a < b) begin
            hit = (t >= a) && (t < b);
        end else if (a > b) begin
            hit = (t >= a) || (t < b);
        end else begin
            hit = 1'b0;
        end
        return hit;
    endfunction

    // Lamp from today's slots and the overnight tail of yesterday's slots.
    function automatic logic lamp_for_day(input int today, input logic [MIN_W-1:0] t);
        int   yday;
        int   idx;
        logic hit;
        yday = (today + DAYS - 1) % DAYS;
        hit  = 1'b0;
        for (int s = 0; s < SLOTS_PER_DAY; s++) begin
            idx = today * SLOTS_PER_DAY + s;
            if (en_tbl[idx] && slot_covers(t, on_tbl[idx], off_tbl[idx])) begin
                hit = 1'b1;
            end
            idx = yday * SLOTS_PER_DAY + s;
            if (en_tbl[idx] && (on_tbl[idx] > off_tbl[idx]) && (t < off_tbl[idx])) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    // Applies one input transfer to the predicted state and returns its result.
    function automatic t_lamp_result predict_lamp(input t_kind kind, input logic [47:0] d);
        t_lamp_result res;
        int           today;
        int           idx;
        res.accepted = 1'b0;
        case (kind)
            KIND_EVAL: begin
                today        = (int'(d[2:0]) + 5) % DAYS;
                lamp_state   = d[14] ? lamp_for_day(today, minutes_of(d[7:3], d[13:8])) : 1'b0;
                res.accepted = 1'b1;
            end
            KIND_WRITE: begin
                if (int'(d[17:15]) < DAYS && int'(d[19:18]) < SLOTS_PER_DAY) begin
                    idx          = int'(d[17:15]) * SLOTS_PER_DAY + int'(d[19:18]);
                    on_tbl[idx]  = minutes_of(d[24:20], d[30:25]);
                    off_tbl[idx] = minutes_of(d[35:31], d[41:36]);
                    en_tbl[idx]  = d[42];
                    res.accepted = 1'b1;
                end
            end
            KIND_CLEAR: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    on_tbl[i]  = '0;
                    off_tbl[i] = '0;
                    en_tbl[i]  = 1'b0;
                end
                res.accepted = 1'b1;
            end
            default: begin
            end
        endcase
        res.lamp_on = lamp_state;
        return res;
    endfunction

    // Compare each result transfer with the oldest prediction, then log new input.
    always @(posedge i_clk) begin : monitor
        t_lamp_result got;
        t_lamp_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                on_tbl[i]  = '0;
                off_tbl[i] = '0;
                en_tbl[i]  = 1'b0;
            end
            lamp_state = 1'b0;
            expected_lamp_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got.lamp_on  = i_out_data[0];
                got.accepted = i_out_data[1];
                if (expected_lamp_q.size() == 0) begin
                    $display("%0t: result with nothing expected: lamp_on=%0b accepted=%0b",
                             $time, got.lamp_on, got.accepted);
                    mismatch_count++;
                end else begin
                    want = expected_lamp_q.pop_front();
                    if (got.lamp_on !== want.lamp_on) begin
                        $display("%0t: lamp_on expected %0b, actual %0b",
                                 $time, want.lamp_on, got.lamp_on);
                        mismatch_count++;
                    end
                    if (got.accepted !== want.accepted) begin
                        $display("%0t: accepted expected %0b, actual %0b",
                                 $time, want.accepted, got.accepted);
                        mismatch_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_lamp_q.push_back(predict_lamp(t_kind'(i_in_kind), i_in_data));
            end
        end
        o_mismatches <= mismatch_count;
        o_pending    <= expected_lamp_q.size();
    end

endmodule

### bench/tb_weekly_time_switch_unit.sv
// Testbench top for the weekly time switch: stimulus, handshake pressure and verdict.
`timescale 1ns / 1ps

module tb_weekly_time_switch_unit
    import wts_pkg::*;
();

    localparam int RANDOM_ITEMS = 700;
    localparam int CYCLE_LIMIT  = 200000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // tdata: weekday, hour, minute, enable, day, slot_number, on_hour, on_minute,
    // off_hour, off_minute, slot_enable, zero fill (lowest bit first)
    logic [47:0] s_axis_tdata;
    // tuser: kind
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // tdata: lamp_on, accepted, zero fill (lowest bit first)
    logic [7:0]  m_axis_tdata;

    int mismatches;
    int pending;
    int burst_left = 0;

    weekly_time_switch_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    wts_lamp_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_in_kind   (s_axis_tuser),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .o_mismatches(mismatches),
        .o_pending   (pending)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog on the total run length.
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    // The receiver switches between always ready, random stalls and long stalls.
    initial begin
        int mode;
        int span;
        m_axis_tready <= 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(5, 60);
            repeat (span) begin
                @(negedge i_clk);
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= ($urandom_range(0, 7) == 0);
                    default: m_axis_tready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    function automatic logic [47:0] pack_fields(
        input logic [2:0] weekday, input logic [4:0] hour, input logic [5:0] minute,
        input logic enable, input logic [2:0] day, input logic [1:0] slot,
        input logic [4:0] on_h, input logic [5:0] on_m, input logic [4:0] off_h,
        input logic [5:0] off_m, input logic slot_en);
        return {5'b0, slot_en, off_m, off_h, on_m, on_h, slot, day, enable,
                minute, hour, weekday};
    endfunction

    // One input transfer, called at a falling edge; bursts end in a random gap.
    task automatic transfer_item(input t_kind kind, input logic [47:0] data);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= data;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic eval_time(input logic [2:0] weekday, input logic [4:0] hour,
                             input logic [5:0] minute, input logic enable);
        transfer_item(KIND_EVAL, pack_fields(weekday, hour, minute, enable,
                                             '0, '0, '0, '0, '0, '0, 1'b0));
    endtask

    task automatic write_slot(input logic [2:0] day, input logic [1:0] slot,
                              input logic [4:0] on_h, input logic [5:0] on_m,
                              input logic [4:0] off_h, input logic [5:0] off_m,
                              input logic slot_en);
        transfer_item(KIND_WRITE, pack_fields('0, '0, '0, 1'b0, day, slot,
                                              on_h, on_m, off_h, off_m, slot_en));
    endtask

    // Mostly well-formed items with random content; the rest use full field ranges.
    task automatic random_item();
        int          pick;
        logic        legal;
        t_kind       kind;
        logic [47:0] data;
        pick  = $urandom_range(0, 99);
        legal = ($urandom_range(0, 9) != 0);
        if (pick < 58) begin
            kind = KIND_EVAL;
        end else if (pick < 94) begin
            kind = KIND_WRITE;
        end else if (pick < 97) begin
            kind = KIND_CLEAR;
        end else begin
            kind = KIND_NONE;
        end
        data = pack_fields(
            3'(legal ? $urandom_range(0, 6) : $urandom_range(0, 7)),
            5'(legal ? $urandom_range(0, 23) : $urandom_range(0, 31)),
            6'(legal ? $urandom_range(0, 59) : $urandom_range(0, 63)),
            legal ? ($urandom_range(0, 6) != 0) : 1'($urandom_range(0, 1)),
            3'(legal ? $urandom_range(0, 6) : $urandom_range(0, 7)),
            2'(legal ? $urandom_range(0, 1) : $urandom_range(0, 3)),
            5'(legal ? $urandom_range(0, 23) : $urandom_range(0, 31)),
            6'(legal ? $urandom_range(0, 59) : $urandom_range(0, 63)),
            5'(legal ? $urandom_range(0, 23) : $urandom_range(0, 31)),
            6'(legal ? $urandom_range(0, 59) : $urandom_range(0, 63)),
            legal ? ($urandom_range(0, 4) != 0) : 1'($urandom_range(0, 1)));
        transfer_item(kind, data);
    endtask

    // Reset, directed cases, random traffic, drain and verdict.
    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= KIND_EVAL;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Empty table after reset, then a daytime slot and its edges.
        eval_time(3'd2, 5'd12, 6'd0, 1'b1);
        write_slot(3'd0, 2'd0, 5'd8, 6'd0, 5'd17, 6'd0, 1'b1);
        eval_time(3'd2, 5'd8, 6'd0, 1'b1);
        eval_time(3'd2, 5'd16, 6'd59, 1'b1);
        eval_time(3'd2, 5'd17, 6'd0, 1'b1);
        eval_time(3'd2, 5'd7, 6'd59, 1'b1);
        eval_time(3'd2, 5'd12, 6'd0, 1'b0);

        // Overnight slot: today's part and yesterday's tail, but not yesterday's start.
        write_slot(3'd0, 2'd1, 5'd22, 6'd0, 5'd6, 6'd0, 1'b1);
        eval_time(3'd2, 5'd23, 6'd0, 1'b1);
        eval_time(3'd3, 5'd5, 6'd59, 1'b1);
        eval_time(3'd3, 5'd6, 6'd0, 1'b1);
        eval_time(3'd3, 5'd22, 6'd30, 1'b1);

        // A slot whose on and off times are equal never matches.
        write_slot(3'd1, 2'd0, 5'd10, 6'd0, 5'd10, 6'd0, 1'b1);
        eval_time(3'd3, 5'd10, 6'd0, 1'b1);

        // Refused writes and the unused kind.
        write_slot(3'd7, 2'd0, 5'd1, 6'd0, 5'd2, 6'd0, 1'b1);
        write_slot(3'd3, 2'd2, 5'd1, 6'd0, 5'd2, 6'd0, 1'b1);
        write_slot(3'd3, 2'd3, 5'd31, 6'd63, 5'd31, 6'd63, 1'b1);
        transfer_item(KIND_NONE, {5'b0, {43{1'b1}}});

        // Weekday seven maps like weekday zero.
        write_slot(3'd5, 2'd0, 5'd0, 6'd0, 5'd1, 6'd0, 1'b1);
        eval_time(3'd7, 5'd0, 6'd30, 1'b1);

        // Yesterday of the first day index is the last one.
        transfer_item(KIND_CLEAR, '0);
        write_slot(3'd6, 2'd1, 5'd20, 6'd0, 5'd3, 6'd0, 1'b1);
        eval_time(3'd2, 5'd2, 6'd59, 1'b1);

        // Disabled slot and time fields beyond their normal range.
        write_slot(3'd4, 2'd0, 5'd0, 6'd0, 5'd23, 6'd59, 1'b0);
        eval_time(3'd6, 5'd12, 6'd0, 1'b1);
        write_slot(3'd2, 2'd1, 5'd31, 6'd63, 5'd0, 6'd0, 1'b1);
        eval_time(3'd4, 5'd31, 6'd63, 1'b1);
        eval_time(3'd4, 5'd0, 6'd0, 1'b1);
        transfer_item(KIND_CLEAR, '0);
        eval_time(3'd4, 5'd31, 6'd63, 1'b1);

        repeat (RANDOM_ITEMS) random_item();
        s_axis_tvalid <= 1'b0;

        // Drain the outstanding results, then allow the pipeline latency.
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
